/* hw/rtl/saturating_fixed_point_alu_macros.svh */
// assertion macros used by the checker file
`ifndef SATURATING_FIXED_POINT_ALU_MACROS_SVH
`define SATURATING_FIXED_POINT_ALU_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SFPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfpa assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SFPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfpa assertion failed");

`endif

/* hw/rtl/sfpa_pkg.sv */
// ----------------------------------------------------------------------------
// sfpa_pkg
// Shared widths, mode codes, pipeline word types and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpa_pkg;

	localparam int unsigned DataW   = 16;
	localparam int unsigned FracW   = 6;
	localparam int unsigned MaxDig  = 4;
	localparam int unsigned DivW    = 32;

	localparam logic signed [DataW-1:0] SatMax = 16'sh7FFF;
	localparam logic signed [DataW-1:0] SatMin = 16'sh8000;

	typedef enum logic [3:0] {
		MODE_ADD      = 4'd0,
		MODE_SUB      = 4'd1,
		MODE_MUL      = 4'd2,
		MODE_DIV      = 4'd3,
		MODE_MULDIV   = 4'd4,
		MODE_NEG      = 4'd5,
		MODE_ABS      = 4'd6,
		MODE_CLAMP    = 4'd7,
		MODE_ADDLIM   = 4'd8,
		MODE_TOINT    = 4'd9,
		MODE_INTPART  = 4'd10,
		MODE_DECFRACT = 4'd11
	} sfpa_mode_t;

	// control carried alongside the division through the cell row
	typedef struct packed {
		logic               vld;
		logic               use_div;
		logic               q_neg;
		logic signed [32:0] r;
	} sfpa_side_t;

	// word moved from one division cell to the next
	typedef struct packed {
		sfpa_side_t        side;
		logic [DataW-1:0]  rem;
		logic [DivW-1:0]   num;
		logic [DivW-1:0]   quo;
		logic [DataW-1:0]  den;
	} sfpa_div_t;

	// saturate a wide signed value to the result range
	function automatic logic signed [DataW-1:0] sat16(input logic signed [33:0] v);
		logic signed [DataW-1:0] res;
		if (v >= 34'(SatMax))
			res = SatMax;
		else if (v <= 34'(SatMin))
			res = SatMin;
		else
			res = v[DataW-1:0];
		return res;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfpa_front.sv */
// ----------------------------------------------------------------------------
// sfpa_front
// Operand register, product register and per-mode result / divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpa_front
	import sfpa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_vld,
	input  wire logic [3:0]              mode,
	input  wire logic signed [15:0]      operand_a,
	input  wire logic signed [15:0]      operand_b,
	input  wire logic signed [15:0]      operand_c,
	input  wire logic signed [15:0]      low_limit,
	input  wire logic signed [15:0]      high_limit,
	input  wire logic [2:0]              digit_count,
	output sfpa_div_t                    div_s2
);

	logic               vld_s1;
	logic [3:0]         mode_s1;
	logic signed [15:0] a_s1, b_s1, c_s1, lo_s1, hi_s1;
	logic [2:0]         dig_s1;
	logic signed [31:0] prod_s1;

	// stage 1: operands and product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
			c_s1    <= operand_c;
			lo_s1   <= low_limit;
			hi_s1   <= high_limit;
			dig_s1  <= digit_count;
			prod_s1 <= operand_a * operand_b;
		end
	end

	logic signed [16:0] sum_ab, dif_ab, neg_a, abs_a;
	logic signed [15:0] sum_sat, clamp_a, clamp_s;
	logic signed [32:0] prod_rnd;
	logic signed [26:0] mul_q;
	logic signed [26:0] dvd;
	logic signed [15:0] dvs;
	logic signed [32:0] t_sh;
	logic signed [16:0] dvs_adj;
	logic signed [16:0] half;
	logic signed [33:0] t_adj;
	logic signed [33:0] t_mag;
	logic signed [16:0] toint_r, intp_r;
	logic [15:0]        dec_m;
	logic [13:0]        scale;
	logic [2:0]         dig_lim;
	logic [20:0]        dec_prod;
	logic signed [32:0] r_sel;
	logic               use_div;
	sfpa_div_t          nxt;

	// add, subtract, negate, absolute value
	assign sum_ab = {a_s1[15], a_s1} + {b_s1[15], b_s1};
	assign dif_ab = {a_s1[15], a_s1} - {b_s1[15], b_s1};
	assign neg_a  = -{a_s1[15], a_s1};
	assign abs_a  = a_s1[15] ? neg_a : {a_s1[15], a_s1};
	assign sum_sat = sat16(34'(sum_ab));

	// clamp with high limit winning on crossed limits
	always_comb begin
		clamp_a = (a_s1 < lo_s1) ? lo_s1 : a_s1;
		clamp_a = (clamp_a > hi_s1) ? hi_s1 : clamp_a;
		clamp_s = (sum_sat < lo_s1) ? lo_s1 : sum_sat;
		clamp_s = (clamp_s > hi_s1) ? hi_s1 : clamp_s;
	end

	// multiply with round half up
	assign prod_rnd = {prod_s1[31], prod_s1} + 33'sd32;
	assign mul_q    = prod_rnd[32:FracW];

	// divider setup: scaled dividend, rounding bias toward away from zero
	assign dvd     = (mode_s1 == MODE_MULDIV) ? mul_q : 27'(a_s1);
	assign dvs     = (mode_s1 == MODE_MULDIV) ? c_s1 : b_s1;
	assign t_sh    = {dvd, {FracW{1'b0}}};
	assign dvs_adj = {dvs[15], dvs} + {16'd0, dvs[15]};
	assign half    = dvs_adj >>> 1;
	assign t_adj   = (t_sh[32] == dvs[15]) ? ({t_sh[32], t_sh} + 34'(half))
	                                       : ({t_sh[32], t_sh} - 34'(half));
	assign t_mag   = t_adj[33] ? -t_adj : t_adj;

	// integer conversions
	assign toint_r = a_s1[15] ? -((neg_a + 17'sd32) >>> FracW)
	                          : (({a_s1[15], a_s1} + 17'sd32) >>> FracW);
	assign intp_r  = a_s1[15] ? -(neg_a >>> FracW) : ({a_s1[15], a_s1} >>> FracW);

	// decimal fraction digits
	assign dec_m   = (a_s1 == SatMin) ? 16'(SatMax) : abs_a[15:0];
	assign dig_lim = (dig_s1 > 3'(MaxDig)) ? 3'(MaxDig) : dig_s1;
	always_comb begin
		case (dig_lim)
			3'd0:    scale = 14'd1;
			3'd1:    scale = 14'd10;
			3'd2:    scale = 14'd100;
			3'd3:    scale = 14'd1000;
			default: scale = 14'd10000;
		endcase
	end
	assign dec_prod = 21'(dec_m[FracW-1:0] * scale) + 21'd32;

	// mode select
	always_comb begin
		use_div = 1'b0;
		case (mode_s1)
			MODE_ADD:      r_sel = 33'(sum_ab);
			MODE_SUB:      r_sel = 33'(dif_ab);
			MODE_MUL:      r_sel = 33'(mul_q);
			MODE_DIV, MODE_MULDIV: begin
				if (dvs == 16'sd0) begin
					r_sel = dvd[26] ? 33'(SatMin) : 33'(SatMax);
				end else begin
					r_sel   = 33'sd0;
					use_div = 1'b1;
				end
			end
			MODE_NEG:      r_sel = 33'(neg_a);
			MODE_ABS:      r_sel = 33'(abs_a);
			MODE_CLAMP:    r_sel = 33'(clamp_a);
			MODE_ADDLIM:   r_sel = 33'(clamp_s);
			MODE_TOINT:    r_sel = 33'(toint_r);
			MODE_INTPART:  r_sel = 33'(intp_r);
			MODE_DECFRACT: r_sel = {18'd0, dec_prod[20:FracW]};
			default:       r_sel = 33'sd0;
		endcase
	end

	always_comb begin
		nxt.side.vld     = vld_s1;
		nxt.side.use_div = use_div;
		nxt.side.q_neg   = t_adj[33] ^ dvs[15];
		nxt.side.r       = r_sel;
		nxt.rem          = '0;
		nxt.num          = t_mag[DivW-1:0];
		nxt.quo          = '0;
		nxt.den          = dvs[15] ? 16'(-dvs) : 16'(dvs);
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s2 <= '0;
		end else if (en) begin
			div_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sfpa_div_cell.sv */
// ----------------------------------------------------------------------------
// sfpa_div_cell
// One restoring-division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpa_div_cell
	import sfpa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire sfpa_div_t d_in,
	output sfpa_div_t      d_q
);

	logic [DataW:0] trial;
	logic           fits;
	sfpa_div_t      nxt;

	// shift in next dividend bit and try to subtract the divisor
	assign trial = {d_in.rem, d_in.num[DivW-1]};
	assign fits  = trial >= {1'b0, d_in.den};

	always_comb begin
		nxt      = d_in;
		nxt.rem  = fits ? 16'(trial - {1'b0, d_in.den}) : trial[DataW-1:0];
		nxt.num  = {d_in.num[DivW-2:0], 1'b0};
		nxt.quo  = {d_in.quo[DivW-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (en) begin
			d_q <= nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/saturating_fixed_point_alu.sv */
// path: operand, stage 2, division cell and output registers
// throughput: one word per cycle when not held; 32 division cells set depth
// the whole pipe advances together and holds while the result is not taken
// reset: asynchronous active low, clears all valid bits; no words in flight
// ----------------------------------------------------------------------------
// saturating_fixed_point_alu
// Saturating Q-format ALU: front stage, division cell row, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module saturating_fixed_point_alu
	import sfpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [3:0]         mode,
	input  wire logic signed [15:0] operand_a,
	input  wire logic signed [15:0] operand_b,
	input  wire logic signed [15:0] operand_c,
	input  wire logic signed [15:0] low_limit,
	input  wire logic signed [15:0] high_limit,
	input  wire logic [2:0]         digit_count,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      result
);

	logic      en;
	sfpa_div_t chain [DivW+1];

	// pipe advances when the output register is free or being drained
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	sfpa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (in_valid),
		.mode        (mode),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.operand_c   (operand_c),
		.low_limit   (low_limit),
		.high_limit  (high_limit),
		.digit_count (digit_count),
		.div_s2      (chain[0])
	);

	// row of division cells
	for (genvar i = 0; i < DivW; i++) begin : g_cell
		sfpa_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (chain[i]),
			.d_q    (chain[i+1])
		);
	end

	logic signed [33:0] q_signed;
	logic signed [33:0] fin;

	// apply quotient sign, pick result, saturate
	assign q_signed = chain[DivW].side.q_neg ? -{2'b00, chain[DivW].quo}
	                                         : {2'b00, chain[DivW].quo};
	assign fin      = chain[DivW].side.use_div ? q_signed
	                                           : {chain[DivW].side.r[32], chain[DivW].side.r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= chain[DivW].side.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= sat16(fin);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sfpa_checker.sv */
// ----------------------------------------------------------------------------
// sfpa_checker
// Port-level checks on the ALU handshake and pipe control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "saturating_fixed_point_alu_macros.svh"

module sfpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] result
);

	// a stalled result word stays shown
	`SFPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result))

	// an offered input word stays offered until taken
	`SFPA_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)

	// input side takes words exactly when the output register can move
	`SFPA_ASSERT_NOW(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready))

	// a new result word only appears where the pipe has moved to load it
	`SFPA_ASSERT_NOW(a_rise_moved, $rose(out_valid), $past(in_ready))

endmodule

bind saturating_fixed_point_alu sfpa_checker u_sfpa_checker (.*);

`default_nettype wire
